// ===== rtl/pipc_pkg.sv =====
package pipc_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_COORD_BITS   = 16;

  localparam logic [1:0] DRAIN_LAST = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_BND,
    ST_WAIT_BND,
    ST_SCAN_CRS,
    ST_WAIT_CRS
  } state_e;

  // one vertex beat travelling alongside the memory read
  typedef struct packed {
    logic vld;
    logic first;
    logic wrap;
    logic crs;
  } pipc_tag_t;

  typedef struct packed {
    logic      clr;
    pipc_tag_t tag;
  } pipc_ctl_t;

  typedef struct packed {
    logic onb;
    logic odd;
  } pipc_res_t;

endpackage

// ===== rtl/point_in_polygon_ray_crossing_top.sv =====
// clear, append and unused opcodes leave busy low; an empty-polygon query answers in the next cycle
// a query reads the vertex memory once per cycle in a boundary pass and, when the point is not on
// the boundary, in a second crossing pass over all stored vertices
// busy covers a query on a non-empty polygon up to its result beat; results cannot be stalled
// reset clears the vertex count and control state; the vertex memory keeps its contents
module point_in_polygon_ray_crossing_top #(
  parameter int MAX_VERTICES = pipc_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pipc_pkg::DEF_COORD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  output logic               valid_o,
  output logic               inside_res_o,
  output logic               on_boundary_o,
  output logic               status_o
);
  import pipc_pkg::*;

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CW   = COORD_BITS;

  state_e state_q, state_d;

  logic                 acc, acc_query, acc_append, acc_clear, scan, last_beat;
  logic signed [CW-1:0] cx, cy, pt_x_q, pt_y_q, rd_x, rd_y;
  logic [CNTW-1:0]      vcnt_q, vcnt_d, k_q, k_d;
  logic [1:0]           drn_q, drn_d;
  logic                 we, re;
  logic [2*CW-1:0]      rdata;
  pipc_ctl_t            ctl;
  pipc_res_t            res;
  logic                 vld_q, vld_d, ins_q, ins_d, onb_q, onb_d, st_q, st_d;

  assign cx = CW'(coord_x_i);
  assign cy = CW'(coord_y_i);

  assign acc        = start && !busy;
  assign acc_query  = acc && (op_e'(opcode_i) == OP_QUERY);
  assign acc_append = acc && (op_e'(opcode_i) == OP_APPEND);
  assign acc_clear  = acc && (op_e'(opcode_i) == OP_CLEAR);

  assign scan      = (state_q == ST_SCAN_BND) || (state_q == ST_SCAN_CRS);
  assign last_beat = (k_q == vcnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_query && (vcnt_q != '0)) state_d = ST_SCAN_BND;
      end
      ST_SCAN_BND: begin
        if (last_beat) state_d = ST_WAIT_BND;
      end
      ST_WAIT_BND: begin
        if (drn_q == DRAIN_LAST) state_d = res.onb ? ST_IDLE : ST_SCAN_CRS;
      end
      ST_SCAN_CRS: begin
        if (last_beat) state_d = ST_WAIT_CRS;
      end
      ST_WAIT_CRS: begin
        if (drn_q == DRAIN_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.clr       = acc_query;
    ctl.tag.vld   = scan;
    ctl.tag.first = scan && (k_q == '0);
    ctl.tag.wrap  = scan && last_beat;
    ctl.tag.crs   = (state_q == ST_SCAN_CRS);
    re            = scan && !last_beat;
    k_d           = scan && !last_beat ? k_q + 1'b1 : '0;
    drn_d         = ((state_q == ST_WAIT_BND) || (state_q == ST_WAIT_CRS)) ? drn_q + 1'b1 : '0;
    we            = 1'b0;
    vcnt_d        = vcnt_q;
    vld_d         = 1'b0;
    ins_d         = ins_q;
    onb_d         = onb_q;
    st_d          = st_q;
    if (acc_clear) begin
      vcnt_d = '0;
    end else if (acc_append && (vcnt_q < CNTW'(MAX_VERTICES))) begin
      we     = 1'b1;
      vcnt_d = vcnt_q + 1'b1;
    end
    if (acc_query && (vcnt_q == '0)) begin
      vld_d = 1'b1;
      ins_d = 1'b0;
      onb_d = 1'b0;
      st_d  = 1'b1;
    end else if ((state_q == ST_WAIT_BND) && (drn_q == DRAIN_LAST) && res.onb) begin
      vld_d = 1'b1;
      ins_d = 1'b1;
      onb_d = 1'b1;
      st_d  = 1'b0;
    end else if ((state_q == ST_WAIT_CRS) && (drn_q == DRAIN_LAST)) begin
      vld_d = 1'b1;
      ins_d = res.odd;
      onb_d = 1'b0;
      st_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vcnt_q  <= '0;
      k_q     <= '0;
      drn_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
      k_q     <= k_d;
      drn_q   <= drn_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    onb_q <= onb_d;
    st_q  <= st_d;
    if (acc_query) begin
      pt_x_q <= cx;
      pt_y_q <= cy;
    end
  end

  pipc_vmem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * CW),
    .AW    (AW)
  ) u_vmem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (vcnt_q[AW-1:0]),
    .wdata_i ({cx, cy}),
    .re_i    (re),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[2*CW-1:CW];
  assign rd_y = rdata[CW-1:0];

  pipc_geom #(
    .COORD_BITS (CW)
  ) u_geom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rd_x_i (rd_x),
    .rd_y_i (rd_y),
    .pt_x_i (pt_x_q),
    .pt_y_i (pt_y_q),
    .res_o  (res)
  );

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = vld_q;
  assign inside_res_o  = ins_q;
  assign on_boundary_o = onb_q;
  assign status_o      = st_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= CNTW'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_onb_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && on_boundary_o |-> inside_res_o && !status_o)
    else $error("boundary result not inside");

  a_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> !inside_res_o && !on_boundary_o)
    else $error("empty polygon result not outside");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_query && (vcnt_q != '0) |=> busy && !valid_o)
    else $error("query on non-empty polygon did not start a scan");

  a_no_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(vcnt_q))
    else $error("vertex count changed during a query");

endmodule

// ===== rtl/pipc_vmem.sv =====
module pipc_vmem #(
  parameter int DEPTH = pipc_pkg::DEF_MAX_VERTICES,
  parameter int WIDTH = 2 * pipc_pkg::DEF_COORD_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import pipc_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pipc_geom.sv =====
module pipc_geom #(
  parameter int COORD_BITS = pipc_pkg::DEF_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pipc_pkg::pipc_ctl_t           ctl_i,
  input  logic signed [COORD_BITS-1:0]  rd_x_i,
  input  logic signed [COORD_BITS-1:0]  rd_y_i,
  input  logic signed [COORD_BITS-1:0]  pt_x_i,
  input  logic signed [COORD_BITS-1:0]  pt_y_i,
  output pipc_pkg::pipc_res_t           res_o
);
  import pipc_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  pipc_tag_t tag_q;

  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS-1:0] v0_x_q, v0_y_q, prev_x_q, prev_y_q;

  logic        found_q, found_d, below_q, below_d;
  logic        row, cur_below, edge_a, hit_a, chg_a;

  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
  logic                 s1_edge_q, s1_hit_q, s1_chg_q, s1_dyp_q, s1_dyn_q, s1_cross_q;

  logic signed [PW-1:0] m_c1_q, m_c2_q, m_d1_q, m_d2_q;
  logic                 s2_edge_q, s2_hit_q, s2_chg_q, s2_dyp_q, s2_dyn_q, s2_cross_q;

  logic signed [SW-1:0] cr, dt;
  logic                 cr_neg, cr_zero, cr_pos, dt_neg;
  logic                 onb_q, onb_d, odd_q, odd_d;

  // stage a: vertex beat from memory or the stored first vertex
  assign cur_x = tag_q.wrap ? v0_x_q : rd_x_i;
  assign cur_y = tag_q.wrap ? v0_y_q : rd_y_i;

  assign row       = (cur_y == pt_y_i);
  assign cur_below = (cur_y < pt_y_i);
  assign edge_a    = tag_q.vld && !tag_q.first;
  assign hit_a     = tag_q.vld && (cur_x == pt_x_i) && row;
  assign chg_a     = edge_a && tag_q.crs && !row && (below_q != cur_below);

  always_comb begin
    found_d = found_q;
    below_d = below_q;
    if (ctl_i.clr) begin
      found_d = 1'b0;
      below_d = 1'b0;
    end else if (tag_q.vld && !tag_q.crs && !found_q && !row) begin
      found_d = 1'b1;
      below_d = cur_below;
    end else if (chg_a) begin
      below_d = !below_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.vld) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
      if (tag_q.first) begin
        v0_x_q <= cur_x;
        v0_y_q <= cur_y;
      end
    end
    ax_q <= DW'(prev_x_q) - DW'(pt_x_i);
    ay_q <= DW'(prev_y_q) - DW'(pt_y_i);
    bx_q <= DW'(cur_x) - DW'(pt_x_i);
    by_q <= DW'(cur_y) - DW'(pt_y_i);
    m_c1_q <= PW'(ax_q) * PW'(by_q);
    m_c2_q <= PW'(ay_q) * PW'(bx_q);
    m_d1_q <= PW'(ax_q) * PW'(bx_q);
    m_d2_q <= PW'(ay_q) * PW'(by_q);
  end

  // stage c: cross and dot signs
  assign cr      = SW'(m_c1_q) - SW'(m_c2_q);
  assign dt      = SW'(m_d1_q) + SW'(m_d2_q);
  assign cr_neg  = cr[SW-1];
  assign cr_zero = (cr == '0);
  assign cr_pos  = !cr_neg && !cr_zero;
  assign dt_neg  = dt[SW-1];

  always_comb begin
    onb_d = onb_q;
    odd_d = odd_q;
    if (ctl_i.clr) begin
      onb_d = 1'b0;
      odd_d = 1'b0;
    end else if (s2_cross_q) begin
      odd_d = odd_q ^ (s2_chg_q && ((cr_neg && s2_dyp_q) || (cr_pos && s2_dyn_q)));
    end else begin
      onb_d = onb_q || s2_hit_q || (s2_edge_q && cr_zero && dt_neg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q      <= '0;
      found_q    <= 1'b0;
      below_q    <= 1'b0;
      s1_edge_q  <= 1'b0;
      s1_hit_q   <= 1'b0;
      s1_chg_q   <= 1'b0;
      s1_dyp_q   <= 1'b0;
      s1_dyn_q   <= 1'b0;
      s1_cross_q <= 1'b0;
      s2_edge_q  <= 1'b0;
      s2_hit_q   <= 1'b0;
      s2_chg_q   <= 1'b0;
      s2_dyp_q   <= 1'b0;
      s2_dyn_q   <= 1'b0;
      s2_cross_q <= 1'b0;
      onb_q      <= 1'b0;
      odd_q      <= 1'b0;
    end else begin
      tag_q      <= ctl_i.tag;
      found_q    <= found_d;
      below_q    <= below_d;
      s1_edge_q  <= edge_a;
      s1_hit_q   <= hit_a;
      s1_chg_q   <= chg_a;
      s1_dyp_q   <= (prev_y_q > cur_y);
      s1_dyn_q   <= (prev_y_q < cur_y);
      s1_cross_q <= tag_q.crs;
      s2_edge_q  <= s1_edge_q;
      s2_hit_q   <= s1_hit_q;
      s2_chg_q   <= s1_chg_q;
      s2_dyp_q   <= s1_dyp_q;
      s2_dyn_q   <= s1_dyn_q;
      s2_cross_q <= s1_cross_q;
      onb_q      <= onb_d;
      odd_q      <= odd_d;
    end
  end

  assign res_o.onb = onb_q;
  assign res_o.odd = odd_q;

endmodule
